// File: design/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int ENTRIES     = 8;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int RANK_W      = IDX_W;
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int CAP_W       = 4;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_SET = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type              req_type;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } t_req;

    typedef struct packed {
        logic                   hit;
        logic [VALUE_WIDTH-1:0] read_value;
        logic                   evicted;
    } t_resp;

endpackage

// File: design/lkvc_core.sv
`timescale 1ns / 1ps

module lkvc_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [lkvc_pkg::CAP_W-1:0]  i_capacity,
    input  lkvc_pkg::t_req              i_req,
    output lkvc_pkg::t_resp             o_resp
);
    import lkvc_pkg::*;

    logic [KEY_WIDTH-1:0]   r_keys   [ENTRIES];
    logic [VALUE_WIDTH-1:0] r_values [ENTRIES];
    logic [ENTRIES-1:0]     r_valid;
    logic [RANK_W-1:0]      r_rank   [ENTRIES];
    logic [CNT_W-1:0]       r_count;

    logic [ENTRIES-1:0]     w_match;
    logic [IDX_W-1:0]       w_found;
    logic [IDX_W-1:0]       w_free;
    logic [IDX_W-1:0]       w_lru;
    logic                   w_hit;
    logic                   w_is_set;
    logic                   w_fill;
    logic                   w_touch;
    logic                   w_age_all;
    logic [IDX_W-1:0]       w_target;
    logic [RANK_W-1:0]      w_old_rank;
    logic [CNT_W-1:0]       w_count_m1;
    logic [CMP_W-1:0]       w_count_x;
    logic [CMP_W-1:0]       w_cap_x;

    assign w_is_set   = (i_req.req_type == REQ_SET);
    assign w_count_m1 = r_count - CNT_W'(1);
    assign w_count_x  = CMP_W'(r_count);
    assign w_cap_x    = CMP_W'(i_capacity);

    always_comb begin
        w_found = '0;
        w_free  = '0;
        w_lru   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_keys[i] == i_req.key);
            if (w_match[i]) begin
                w_found = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                w_free = IDX_W'(i);
            end
            if (r_valid[i] && (r_rank[i] == w_count_m1[RANK_W-1:0])) begin
                w_lru = IDX_W'(i);
            end
        end
    end

    assign w_hit   = |w_match;
    assign w_fill  = !w_hit && w_is_set && (r_count < CNT_W'(ENTRIES))
                     && ((i_capacity == '0) ? (r_count == '0) : (w_count_x < w_cap_x));
    assign w_touch = w_hit || w_is_set;

    always_comb begin
        w_age_all = 1'b0;
        if (w_hit) begin
            w_target   = w_found;
            w_old_rank = r_rank[w_found];
        end else if (w_fill) begin
            w_target   = w_free;
            w_old_rank = '0;
            w_age_all  = 1'b1;
        end else begin
            w_target   = w_lru;
            w_old_rank = r_rank[w_lru];
        end
    end

    always_comb begin
        o_resp.hit        = w_hit;
        o_resp.read_value = (w_hit && !w_is_set) ? r_values[w_found] : '0;
        o_resp.evicted    = w_is_set && !w_hit && !w_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_fire && w_touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == w_target) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (w_age_all || (r_rank[i] < w_old_rank))) begin
                    r_rank[i] <= r_rank[i] + RANK_W'(1);
                end
            end
            if (w_fill) begin
                r_valid[w_target] <= 1'b1;
                r_count           <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_is_set) begin
            r_keys[w_target]   <= i_req.key;
            r_values[w_target] <= i_req.value;
        end
    end

endmodule

// File: design/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// Fully associative key-value cache, LRU replacement, 8 entries.
// Request channel (i_in_valid/o_in_ready/i_in_data): a get or a set with key
// and value. Response channel (o_out_valid/i_out_ready/o_out_data): exactly
// one response per request, in request order: hit, read value, evicted.
// Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data): capacity, always
// ready; write it only while no request is in flight.
// Path: a transferred request enters the input register, then lookup/update
// writes the result register, which drives the response on the port.
// Throughput: one request per cycle while the response side does not stall;
// lookup, LRU rank update and write all happen between the two registers.
// Stall: when i_out_ready is low the response holds; one more request is
// taken into the input register, then o_in_ready drops.
// Reset (synchronous, active low): all entries invalid, capacity 8, both
// pipeline registers empty. No clearing pass; ready in the cycle after reset.
module lru_key_value_cache_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lkvc_pkg::t_req              i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lkvc_pkg::t_resp             o_out_data
);
    import lkvc_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             r_in_valid;
    t_req             r_in;
    logic             r_out_valid;
    t_resp            r_out;
    logic             w_advance;
    logic             w_fire;
    t_resp            w_resp;

    assign o_cfg_ready = 1'b1;
    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_fire      = r_in_valid && w_advance;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= w_resp;
        end
    end

    lkvc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_capacity (r_capacity),
        .i_req      (r_in),
        .o_resp     (w_resp)
    );

endmodule

// File: design/lkvc_checker.sv
`timescale 1ns / 1ps

module lkvc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  lkvc_pkg::t_resp             o_out_data
);
    import lkvc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("response changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid right after reset");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.evicted))
        else $error("hit and eviction in one response");

    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.read_value != '0) |-> o_out_data.hit)
        else $error("nonzero read value without hit");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request stalled with empty response register");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/sv/tb_lru_key_value_cache_top.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache_top;
    import lkvc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int NUM_PHASES      = 9;
    localparam int LONG_HOLD       = 60;
    localparam int SETTLE_CYCLES   = 4;
    localparam int KEY_POOL        = 12;
    localparam int REPORT_LIMIT    = 10;
    localparam int NUM_DIRECTED    = 24;

    localparam logic [CAP_W-1:0] CAP_PLAN [NUM_PHASES] = '{
        4'd15, 4'd1, 4'd0, 4'd8, 4'd3, 4'd2, 4'd8, 4'd5, 4'd1
    };

    typedef struct packed {
        t_req_type              op;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] val;
        logic                   typed;
        logic                   hit;
        logic [VALUE_WIDTH-1:0] rd;
        logic                   ev;
    } t_dir_row;

    // typed rows carry the response that is obvious from the request history
    localparam t_dir_row DIRECTED_REQS [NUM_DIRECTED] = '{
        '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_GET, 32'h0000_0000, 32'hAAAA_5555, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
        '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678, 1'b0},
        '{REQ_SET, 32'h0000_0001, 32'h0000_0101, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0002, 32'h0000_0102, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0003, 32'h0000_0103, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0004, 32'h0000_0104, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0005, 32'h0000_0105, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0006, 32'h0000_0106, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0007, 32'h0000_0107, 1'b1, 1'b0, 32'h0000_0000, 1'b1},
        '{REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0008, 32'h0000_0108, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_SET, 32'h8000_0000, 32'h8000_0001, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{REQ_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_req             i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_resp            o_out_data;

    lru_key_value_cache_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the cache contents and recency order
    logic [KEY_WIDTH-1:0]   line_key [ENTRIES];
    logic [VALUE_WIDTH-1:0] line_val [ENTRIES];
    bit                     line_vld [ENTRIES];
    int unsigned            line_age [ENTRIES];
    int unsigned            lines_used;
    logic [CAP_W-1:0]       cap_shadow;

    t_resp                  replies_due [$];
    logic [KEY_WIDTH-1:0]   key_pool [KEY_POOL];
    int                     mismatches   = 0;
    int                     stall_cycles = 0;
    int                     hold_left    = 0;
    bit                     no_idle      = 1'b0;

    function automatic void make_newest(int slot, int unsigned old_age);
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_vld[i] && i != slot && line_age[i] < old_age) begin
                line_age[i]++;
            end
        end
        line_age[slot] = 0;
    endfunction

    function automatic t_resp lru_access(t_req r);
        t_resp       res;
        int          slot;
        int unsigned worst;
        int unsigned cap_eff;
        bit          found;
        bit          any;
        res   = '0;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found && line_vld[i] && line_key[i] == r.key) begin
                found = 1'b1;
                slot  = i;
            end
        end
        res.hit = found;
        if (found) begin
            if (r.req_type == REQ_SET) begin
                line_val[slot] = r.value;
            end else begin
                res.read_value = line_val[slot];
            end
            make_newest(slot, line_age[slot]);
        end else if (r.req_type == REQ_SET) begin
            cap_eff = (cap_shadow == '0) ? 1 :
                      (cap_shadow > ENTRIES) ? ENTRIES : cap_shadow;
            if (lines_used < cap_eff && lines_used < ENTRIES) begin
                any = 1'b0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!any && !line_vld[i]) begin
                        any  = 1'b1;
                        slot = i;
                    end
                end
                line_vld[slot] = 1'b1;
                lines_used++;
                make_newest(slot, ENTRIES);
            end else begin
                any   = 1'b0;
                worst = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (line_vld[i] && (!any || line_age[i] > worst)) begin
                        worst = line_age[i];
                        slot  = i;
                        any   = 1'b1;
                    end
                end
                res.evicted = 1'b1;
                make_newest(slot, worst);
            end
            line_key[slot] = r.key;
            line_val[slot] = r.value;
        end
        return res;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.req_type = $urandom_range(1) ? REQ_SET : REQ_GET;
        r.key      = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                                : $urandom;
        r.value    = $urandom;
        return r;
    endfunction

    task automatic offer_req(input t_req r, input bit typed, input t_resp typed_resp);
        t_resp predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = lru_access(r);
        replies_due.push_back(typed ? typed_resp : predicted);
    endtask

    task automatic maybe_gap();
        if (!no_idle && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_shadow = cap;
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 33);
        end
    end

    always @(posedge i_clk) begin
        t_resp due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: response with none pending: hit=%b rd=%h ev=%b", $realtime,
                             o_out_data.hit, o_out_data.read_value, o_out_data.evicted);
                end
            end else begin
                due = replies_due.pop_front();
                if (o_out_data.hit !== due.hit || o_out_data.read_value !== due.read_value ||
                    o_out_data.evicted !== due.evicted) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: mismatch exp hit=%b rd=%h ev=%b, got hit=%b rd=%h ev=%b",
                                 $realtime, due.hit, due.read_value, due.evicted,
                                 o_out_data.hit, o_out_data.read_value, o_out_data.evicted);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_req  req;
        t_resp typed_resp;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            line_key[i] = '0;
            line_val[i] = '0;
            line_vld[i] = 1'b0;
            line_age[i] = 0;
        end
        lines_used = 0;
        cap_shadow = CAP_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < NUM_DIRECTED; n++) begin
            req.req_type          = DIRECTED_REQS[n].op;
            req.key               = DIRECTED_REQS[n].key;
            req.value             = DIRECTED_REQS[n].val;
            typed_resp.hit        = DIRECTED_REQS[n].hit;
            typed_resp.read_value = DIRECTED_REQS[n].rd;
            typed_resp.evicted    = DIRECTED_REQS[n].ev;
            offer_req(req, DIRECTED_REQS[n].typed, typed_resp);
            maybe_gap();
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            write_capacity(CAP_PLAN[ph]);
            for (int k = 0; k < KEY_POOL; k++) begin
                key_pool[k] = $urandom;
            end
            key_pool[0] = '0;
            key_pool[1] = '1;
            no_idle = (ph == 6);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // long output back-pressure while requests keep coming
                if (ph == 3 && k == 30) begin
                    hold_left = LONG_HOLD;
                end
                // full drain in the middle of a phase
                if (ph == 5 && k == 40) begin
                    settle();
                end
                offer_req(rand_req(), 1'b0, '0);
                maybe_gap();
            end
        end
        no_idle = 1'b0;
        settle();

        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
